>>> sv/srb_pkg.sv
// ----------------------------------------------------------------------------
// srb_pkg
// Types and constants shared by the sequence-tagged reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int SEQ_W  = 20;
    localparam int PORT_W = 64;
    localparam int HI_W   = 21;
    localparam int IDX_OUT_W = 4;

    // Highest-inserted starts at minus one.
    localparam logic signed [HI_W-1:0] HI_INS_RESET   = '1;
    localparam logic [SEQ_W-1:0]       LAST_SEQ_RESET = '1;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_HIT      = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTYET   = 3'd4
    } status_t;

endpackage

>>> sv/sequence_tagged_reorder_buffer.sv
// ----------------------------------------------------------------------------
// sequence_tagged_reorder_buffer
// Pool of tagged payload slots with insert, remove-by-number and miss window.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The sequencer then walks
// the slots one per cycle through the single read port of the tag memory,
// testing each with one shared compare (free slot for an insert, valid slot
// with a matching tag for a remove). A word that stops at slot k shows its
// result once slot k has been read and compared; a remove that misses every
// slot then works out the miss window in the states S_WIN_A and S_WIN_B.
// busy drops in the cycle the result is shown, so the next word may be taken
// at that edge. The result is valid for exactly one cycle while done is high;
// the receiver cannot stall it. last_seq may be written only while busy is low.
// ----------------------------------------------------------------------------
module sequence_tagged_reorder_buffer #(
    parameter int SLOTS     = 16,
    parameter int DATA_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           func,
    input  logic [srb_pkg::SEQ_W-1:0]      seq_num,
    input  logic [srb_pkg::PORT_W-1:0]     payload,
    output logic                           done,
    output logic [2:0]                     status,
    output logic [srb_pkg::IDX_OUT_W-1:0]  slot_index,
    output logic [srb_pkg::PORT_W-1:0]     read_data,
    input  logic                           cfg_wr_en,
    input  logic [srb_pkg::SEQ_W-1:0]      cfg_wr_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int WIN_W = srb_pkg::HI_W + 1 + CNT_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WIN_A = 4'b0100,
        S_WIN_B = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic                             pend_reg, pend_next;
    logic [IDX_W-1:0]                 chk_idx_reg, chk_idx_next;
    logic [SLOTS-1:0]                 valid_reg, valid_next;
    logic [CNT_W-1:0]                 occ_reg, occ_next;
    logic signed [srb_pkg::HI_W-1:0]  hi_ins_reg, hi_ins_next;
    logic [srb_pkg::SEQ_W-1:0]        last_seq_reg;
    logic                             done_reg, done_next;

    logic                             func_reg;
    logic [srb_pkg::SEQ_W-1:0]        seq_reg;
    logic [DATA_BITS-1:0]             data_reg;
    logic signed [WIN_W-1:0]          win_hi_reg, win_hi_next;
    logic signed [WIN_W-1:0]          win_lo_reg, win_lo_next;
    srb_pkg::status_t                 status_reg, status_next;
    logic [IDX_W-1:0]                 slot_reg, slot_next;
    logic [DATA_BITS-1:0]             rdata_reg, rdata_next;

    logic                             mem_we;
    logic [srb_pkg::SEQ_W-1:0]        mem_rd_tag;
    logic [DATA_BITS-1:0]             mem_rd_data;

    logic                             accept;
    logic                             match;
    logic                             last_chk;
    logic signed [WIN_W-1:0]          hi_ext, occ_ext, seq_ext, hi_clamped, last_ext;
    logic [IDX_W+3:0]                 slot_wide;

    srb_slot_mem #(
        .SLOTS     (SLOTS),
        .DATA_BITS (DATA_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (chk_idx_reg),
        .wr_tag  (seq_reg),
        .wr_data (data_reg),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_tag  (mem_rd_tag),
        .rd_data (mem_rd_data)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign last_chk = (chk_idx_reg == IDX_W'(SLOTS - 1));

    // Shared compare: a free slot for an insert, a held slot with the tag for a remove.
    assign match = pend_reg && ((func_reg == srb_pkg::FUNC_INSERT) ? !valid_reg[chk_idx_reg]
                   : (valid_reg[chk_idx_reg] && (mem_rd_tag == seq_reg)));

    assign mem_we = (state_reg == S_SCAN) && match && (func_reg == srb_pkg::FUNC_INSERT);

    assign hi_ext   = WIN_W'(hi_ins_reg);
    assign occ_ext  = $signed(WIN_W'(occ_reg));
    assign seq_ext  = $signed(WIN_W'(seq_reg));
    assign last_ext = $signed(WIN_W'(last_seq_reg));
    assign hi_clamped = (win_hi_reg > last_ext) ? last_ext : win_hi_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = 1'b0;
        chk_idx_next = chk_idx_reg;
        valid_next   = valid_reg;
        occ_next     = occ_reg;
        hi_ins_next  = hi_ins_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        slot_next    = slot_reg;
        rdata_next   = rdata_reg;
        win_hi_next  = win_hi_reg;
        win_lo_next  = win_lo_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                // Issue the read of the next slot while checking the one read before.
                if (cnt_reg < CNT_W'(SLOTS))
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    pend_next    = 1'b1;
                    chk_idx_next = cnt_reg[IDX_W-1:0];
                end
                if (match)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    slot_next  = chk_idx_reg;
                    if (func_reg == srb_pkg::FUNC_INSERT)
                    begin
                        valid_next[chk_idx_reg] = 1'b1;
                        occ_next    = occ_reg + 1'b1;
                        status_next = srb_pkg::ST_INSERTED;
                        rdata_next  = '0;
                        if ($signed({1'b0, seq_reg}) > hi_ins_reg)
                        begin
                            hi_ins_next = $signed({1'b0, seq_reg});
                        end
                    end
                    else
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        occ_next    = occ_reg - 1'b1;
                        status_next = srb_pkg::ST_HIT;
                        rdata_next  = mem_rd_data;
                    end
                end
                else if (pend_reg && last_chk)
                begin
                    slot_next  = '0;
                    rdata_next = '0;
                    if (func_reg == srb_pkg::FUNC_INSERT)
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        status_next = srb_pkg::ST_FULL;
                    end
                    else
                    begin
                        state_next = S_WIN_A;
                    end
                end
            end
            S_WIN_A:
            begin
                win_hi_next = hi_ext + WIN_W'(SLOTS) - occ_ext - WIN_W'(1);
                win_lo_next = hi_ext - occ_ext + WIN_W'(1);
                state_next  = S_WIN_B;
            end
            S_WIN_B:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if ((seq_ext > hi_clamped) || (seq_ext < win_lo_reg))
                begin
                    status_next = srb_pkg::ST_RANGE;
                end
                else
                begin
                    status_next = srb_pkg::ST_NOTYET;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            chk_idx_reg  <= '0;
            valid_reg    <= '0;
            occ_reg      <= '0;
            hi_ins_reg   <= srb_pkg::HI_INS_RESET;
            last_seq_reg <= srb_pkg::LAST_SEQ_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            chk_idx_reg <= chk_idx_next;
            valid_reg   <= valid_next;
            occ_reg     <= occ_next;
            hi_ins_reg  <= hi_ins_next;
            done_reg    <= done_next;
            if (cfg_wr_en)
            begin
                last_seq_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            seq_reg  <= seq_num;
            data_reg <= payload[DATA_BITS-1:0];
        end
        win_hi_reg <= win_hi_next;
        win_lo_reg <= win_lo_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        rdata_reg  <= rdata_next;
    end

    assign slot_wide  = {4'b0000, slot_reg};
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot_index = slot_wide[3:0];
    assign read_data  = srb_pkg::PORT_W'(rdata_reg);

    // The slot count always agrees with the valid bits.
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == CNT_W'($countones(valid_reg)))
        else $error("occupied count disagrees with valid bits");

    // A result word only follows a cycle of work.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != S_IDLE))
        else $error("result strobe without a word in progress");

    // A full refusal only happens with every slot held.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == srb_pkg::ST_FULL)) |-> (occ_reg == CNT_W'(SLOTS)))
        else $error("full status with a free slot");

    // An accepted word makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("word accepted but block not busy");

    // A hit frees the slot it reports.
    a_hit_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == srb_pkg::ST_HIT)) |-> !valid_reg[slot_reg])
        else $error("hit slot still marked valid");

endmodule

>>> sv/srb_slot_mem.sv
// ----------------------------------------------------------------------------
// srb_slot_mem
// Slot tag and payload storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module srb_slot_mem #(
    parameter int SLOTS     = 16,
    parameter int DATA_BITS = 64
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(SLOTS)-1:0]      wr_addr,
    input  logic [srb_pkg::SEQ_W-1:0]     wr_tag,
    input  logic [DATA_BITS-1:0]          wr_data,
    input  logic [$clog2(SLOTS)-1:0]      rd_addr,
    output logic [srb_pkg::SEQ_W-1:0]     rd_tag,
    output logic [DATA_BITS-1:0]          rd_data
);

    logic [srb_pkg::SEQ_W-1:0] tag_mem  [SLOTS];
    logic [DATA_BITS-1:0]      data_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr]  <= wr_tag;
            data_mem[wr_addr] <= wr_data;
        end
        rd_tag  <= tag_mem[rd_addr];
        rd_data <= data_mem[rd_addr];
    end

endmodule

>>> tb/sv/tb_sequence_tagged_reorder_buffer.sv
// ----------------------------------------------------------------------------
// tb_sequence_tagged_reorder_buffer
// Self-checking bench for the reorder buffer: a slot-pool model predicts the
// status, slot and payload of every word and checks each done pulse in order,
// across several last_seq settings.
// ----------------------------------------------------------------------------
module tb_sequence_tagged_reorder_buffer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEQ_W       = srb_pkg::SEQ_W;
    localparam int PORT_W      = srb_pkg::PORT_W;
    localparam int IDX_OUT_W   = srb_pkg::IDX_OUT_W;
    localparam int SLOT_COUNT  = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [SEQ_W-1:0] SEQ_TOP = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  func;
    logic [SEQ_W-1:0]      seq_num;
    logic [PORT_W-1:0]     payload;
    logic                  done;
    logic [2:0]            status;
    logic [IDX_OUT_W-1:0]  slot_index;
    logic [PORT_W-1:0]     read_data;
    logic                  cfg_wr_en;
    logic [SEQ_W-1:0]      cfg_wr_data;

    typedef struct {
        logic                 op;
        logic [SEQ_W-1:0]     seq;
        srb_pkg::status_t     status;
        logic [IDX_OUT_W-1:0] slot;
        logic [PORT_W-1:0]    rdata;
    } reply_t;

    class reorder_pool_model;
        bit                 live [SLOT_COUNT];
        logic [SEQ_W-1:0]   tag [SLOT_COUNT];
        logic [PORT_W-1:0]  data [SLOT_COUNT];
        int                 highest;
        int                 occupied;
        int                 last_seq;
        int                 errors;
        reply_t             owed_replies [$];

        function new();
            foreach (live[k]) live[k] = 1'b0;
            highest  = -1;
            occupied = 0;
            last_seq = int'(srb_pkg::LAST_SEQ_RESET);
            errors   = 0;
        endfunction

        function void set_last_seq(logic [SEQ_W-1:0] v);
            last_seq = int'(v);
        endfunction

        // Returns the tag of a randomly chosen occupied slot, if any.
        function bit pick_held(output logic [SEQ_W-1:0] s);
            int k;
            int n;
            n = $urandom_range(0, SLOT_COUNT - 1);
            for (k = 0; k < SLOT_COUNT; k++) begin
                if (live[(n + k) % SLOT_COUNT]) begin
                    s = tag[(n + k) % SLOT_COUNT];
                    return 1'b1;
                end
            end
            s = '0;
            return 1'b0;
        endfunction

        task flag_mismatch(string msg);
            if (errors < 100)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        function void log_word(logic op, logic [SEQ_W-1:0] s, logic [PORT_W-1:0] p);
            reply_t r;
            int     k;
            int     found;
            int     lo;
            int     hi;
            r.op     = op;
            r.seq    = s;
            r.status = srb_pkg::ST_INSERTED;
            r.slot   = '0;
            r.rdata  = '0;
            found    = -1;
            if (op == srb_pkg::FUNC_INSERT) begin
                for (k = 0; k < SLOT_COUNT; k++)
                    if (!live[k] && found < 0) found = k;
                if (found < 0) begin
                    r.status = srb_pkg::ST_FULL;
                end else begin
                    live[found] = 1'b1;
                    tag[found]  = s;
                    data[found] = p;
                    if (int'(s) > highest) highest = int'(s);
                    occupied++;
                    r.slot = found[IDX_OUT_W-1:0];
                end
            end else begin
                for (k = 0; k < SLOT_COUNT; k++)
                    if (live[k] && tag[k] == s && found < 0) found = k;
                if (found >= 0) begin
                    r.rdata     = data[found];
                    live[found] = 1'b0;
                    occupied--;
                    r.status = srb_pkg::ST_HIT;
                    r.slot   = found[IDX_OUT_W-1:0];
                end else begin
                    // Window of numbers that could still show up given what is held.
                    hi = highest + SLOT_COUNT - occupied - 1;
                    lo = highest - occupied + 1;
                    if (hi > last_seq) hi = last_seq;
                    r.status = (int'(s) > hi || int'(s) < lo) ? srb_pkg::ST_RANGE
                                                              : srb_pkg::ST_NOTYET;
                end
            end
            owed_replies.push_back(r);
        endfunction

        task check_reply(logic [2:0] st, logic [IDX_OUT_W-1:0] idx, logic [PORT_W-1:0] rd);
            reply_t e;
            if (owed_replies.size() == 0) begin
                flag_mismatch($sformatf("reply with status %0d while no word is pending", st));
                return;
            end
            e = owed_replies.pop_front();
            if (st !== e.status)
                flag_mismatch($sformatf("op %0d seq %0h: status %0d, expected %0d",
                                        e.op, e.seq, st, e.status));
            if (idx !== e.slot)
                flag_mismatch($sformatf("op %0d seq %0h: slot_index %0d, expected %0d",
                                        e.op, e.seq, idx, e.slot));
            if (rd !== e.rdata)
                flag_mismatch($sformatf("op %0d seq %0h: read_data %0h, expected %0h",
                                        e.op, e.seq, rd, e.rdata));
        endtask
    endclass

    reorder_pool_model pool = new();

    int  cycle_count = 0;
    int  cursor;
    bit  no_gaps;
    bit  noise_inserts;

    sequence_tagged_reorder_buffer uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .seq_num     (seq_num),
        .payload     (payload),
        .done        (done),
        .status      (status),
        .slot_index  (slot_index),
        .read_data   (read_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Results are checked before a new word is noted, since a word may be
    // taken at the very edge that ends the previous done cycle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                pool.check_reply(status, slot_index, read_data);
            if (start && !busy)
                pool.log_word(func, seq_num, payload);
        end
    end

    // Presents one word and returns at the edge that takes it.
    task send_word(logic op, logic [SEQ_W-1:0] s, logic [PORT_W-1:0] p, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        func    <= op;
        seq_num <= s;
        payload <= p;
        start   <= 1'b1;
        while (busy) @(negedge clk);
        @(posedge clk);
    endtask

    task drain_pool_replies();
        @(negedge clk);
        start <= 1'b0;
        while (pool.owed_replies.size() != 0 || busy) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task write_last_seq(logic [SEQ_W-1:0] v);
        drain_pool_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pool.set_last_seq(v);
    endtask

    // Mostly a stream of nearby numbers inserted a little out of order and
    // drained by a consumer, with some stray removes (and inserts late on).
    task random_word(int insert_pct);
        int               r;
        int               gap;
        int               seqv;
        logic             op;
        logic [SEQ_W-1:0] s;
        logic [PORT_W-1:0] p;
        r = $urandom_range(0, 99);
        p = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) no_gaps = !no_gaps;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (r < 8)
        begin
            op = srb_pkg::FUNC_REMOVE;
            s  = SEQ_W'($urandom_range(0, int'(SEQ_TOP)));
        end
        else if (noise_inserts && r < 14)
        begin
            op = srb_pkg::FUNC_INSERT;
            s  = SEQ_W'($urandom_range(0, int'(SEQ_TOP)));
        end
        else if (r < insert_pct)
        begin
            op   = srb_pkg::FUNC_INSERT;
            seqv = cursor + $urandom_range(0, 6);
            s    = seqv[SEQ_W-1:0];
            if ($urandom_range(0, 1)) cursor++;
        end
        else
        begin
            op = srb_pkg::FUNC_REMOVE;
            if ($urandom_range(0, 3) != 0 || !pool.pick_held(s))
            begin
                seqv = cursor + $urandom_range(0, 24) - 14;
                s    = seqv[SEQ_W-1:0];
            end
        end
        send_word(op, s, p, gap);
        if ($urandom_range(0, 99) == 0) drain_pool_replies();
    endtask

    initial
    begin
        int               ph;
        int               n;
        logic [SEQ_W-1:0] limit_val;
        rst_n         = 1'b0;
        start         = 1'b0;
        func          = srb_pkg::FUNC_INSERT;
        seq_num       = '0;
        payload       = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        no_gaps       = 1'b0;
        noise_inserts = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Misses on an empty pool, duplicates, freed slots that must not
        // match, then a full pool and a refused insert.
        send_word(srb_pkg::FUNC_REMOVE, 20'd0, '0, 0);
        send_word(srb_pkg::FUNC_REMOVE, SEQ_TOP, '1, 2);
        send_word(srb_pkg::FUNC_INSERT, 20'd5, '1, 0);
        send_word(srb_pkg::FUNC_INSERT, 20'd3, '0, 0);
        send_word(srb_pkg::FUNC_INSERT, 20'd3, 64'h0123_4567_89ab_cdef, 5);
        send_word(srb_pkg::FUNC_REMOVE, 20'd3, '0, 0);
        send_word(srb_pkg::FUNC_REMOVE, 20'd3, '0, 0);
        send_word(srb_pkg::FUNC_REMOVE, 20'd3, '0, 1);
        send_word(srb_pkg::FUNC_REMOVE, 20'd9, '0, 0);
        send_word(srb_pkg::FUNC_REMOVE, 20'd20, '0, 0);
        for (n = 6; n <= 20; n++)
            send_word(srb_pkg::FUNC_INSERT, n[SEQ_W-1:0], {$urandom, $urandom}, 0);
        send_word(srb_pkg::FUNC_INSERT, 20'd21, '1, 0);
        send_word(srb_pkg::FUNC_REMOVE, 20'd5, '0, 3);

        cursor = 21;
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:       limit_val = '0;
                1:       limit_val = cursor[SEQ_W-1:0] + 20'd4;
                2:       limit_val = SEQ_TOP;
                4:       limit_val = cursor[SEQ_W-1:0] + 20'd12;
                6:       limit_val = cursor[SEQ_W-1:0];
                7:       limit_val = SEQ_TOP;
                default: limit_val = SEQ_W'($urandom_range(0, int'(SEQ_TOP)));
            endcase
            write_last_seq(limit_val);
            if (ph == 7)
            begin
                cursor        = int'(SEQ_TOP) - 64;
                noise_inserts = 1'b1;
            end
            for (n = 0; n < 128; n++)
                random_word(((ph % 3) == 0) ? 70 : ((ph % 3) == 1) ? 38 : 54);
        end
        send_word(srb_pkg::FUNC_INSERT, SEQ_TOP, '1, 0);
        send_word(srb_pkg::FUNC_REMOVE, SEQ_TOP, '0, 0);

        drain_pool_replies();
        repeat (25) @(negedge clk);
        if (pool.owed_replies.size() != 0)
            pool.flag_mismatch($sformatf("%0d replies never arrived",
                                         pool.owed_replies.size()));
        if (pool.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sequence_tagged_reorder_buffer.f
sv/srb_pkg.sv
sv/srb_slot_mem.sv
sv/sequence_tagged_reorder_buffer.sv
tb/sv/tb_sequence_tagged_reorder_buffer.sv
